// ----- hw/rtl/fmac_pkg.sv -----
// Shared types, constants and helpers for the fence monitor alarm controller.
package fmac_pkg;

	// Command codes carried by an input item.
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_PACKET = 1'b1;

	// Charge byte codes found in a packet; any other value leaves the counter alone.
	localparam logic [7:0] CHARGE_ON  = 8'd0;
	localparam logic [7:0] CHARGE_OFF = 8'd1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SAVED_THRESHOLD   = 2'd0,
		REG_LINK_ALARM_TICKS  = 2'd1,
		REG_LOW_READING_LIMIT = 2'd2,
		REG_LONG_PRESS_TICKS  = 2'd3
	} cfg_index_t;

	localparam int CFG_DATA_W = 8;

	// Configuration reset values.
	localparam logic [2:0] SAVED_THR_RST   = 3'd0;
	localparam logic [7:0] LINK_TICKS_RST  = 8'd200;
	localparam logic [3:0] LOW_LIMIT_RST   = 4'd5;
	localparam logic [4:0] LONG_PRESS_RST  = 5'd15;

	// Timing and limit constants.
	localparam logic [2:0] THR_MAX         = 3'd5;
	localparam logic [4:0] LINK_AGE_RST    = 5'd10;
	localparam logic [4:0] LINK_LOST_AGE   = 5'd20;
	localparam logic [4:0] LINK_AGE_CAP    = 5'd25;
	localparam logic [4:0] LIGHT_PRESS     = 5'd30;
	localparam logic [4:0] LIGHT_NORMAL    = 5'd20;
	localparam logic [4:0] LIGHT_ALARM     = 5'd5;
	localparam logic [4:0] EXIT_TICKS      = 5'd20;
	localparam logic [5:0] CHARGE_CAP      = 6'd50;
	localparam logic [5:0] CHARGE_STEP     = 6'd5;
	localparam logic [3:0] LOW_COUNT_MAX   = 4'd15;
	localparam logic [7:0] SILENCE_MAX     = 8'd255;
	localparam logic [4:0] HOLD_MAX        = 5'd31;

	// One input beat.
	typedef struct packed {
		logic       command;
		logic       button_pressed;
		logic [7:0] fence_level;
		logic [7:0] charge_state;
	} in_item_t;

	// One result beat.
	typedef struct packed {
		logic       buzzer_on;
		logic       backlight_on;
		logic       fence_alarm;
		logic       link_alarm;
		logic       link_lost;
		logic       in_settings;
		logic       marker_visible;
		logic [2:0] active_threshold;
		logic [2:0] pending_threshold;
		logic       charging_shown;
		logic       save_request;
	} out_item_t;

	// A stored threshold outside 0..5 falls back to zero.
	function automatic logic [2:0] clamp_thr(input logic [2:0] v);
		return (v > THR_MAX) ? 3'd0 : v;
	endfunction

endpackage

// ----- hw/rtl/fmac_core.sv -----
// Alarm, backlight, settings and charge state with its one-beat update logic.
module fmac_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  fmac_pkg::cfg_index_t                cfg_index,
	input  logic [fmac_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                valid_s1,
	input  fmac_pkg::in_item_t                  item_s1,
	output fmac_pkg::out_item_t                 result_s1
);

	// Configuration registers; the saved threshold acts only through the thresholds it loads.
	logic [7:0] link_ticks_q;
	logic [3:0] low_limit_q;
	logic [4:0] long_press_q;

	// Controller state.
	logic [4:0] age_q, age_d;
	logic [4:0] light_time_q, light_time_d;
	logic       light_q, light_d;
	logic       buzz_q, buzz_d;
	logic       fence_flag_q, fence_flag_d;
	logic       fence_sil_q, fence_sil_d;
	logic [3:0] low_cnt_q, low_cnt_d;
	logic       link_flag_q, link_flag_d;
	logic       link_sil_q, link_sil_d;
	logic [7:0] silence_q, silence_d;
	logic [4:0] hold_q, hold_d;
	logic       settings_q, settings_d;
	logic [1:0] blink_q, blink_d;
	logic       released_q, released_d;
	logic [2:0] edit_thr_q, edit_thr_d;
	logic [2:0] thr_q, thr_d;
	logic [4:0] exit_q, exit_d;
	logic [5:0] charge_q, charge_d;
	logic       save_d;
	logic       btn;
	logic       low_read;

	assign btn      = item_s1.button_pressed;
	assign low_read = item_s1.fence_level <= {5'd0, thr_q};

	// Next state for the beat in the input register.
	always_comb begin
		age_d        = age_q;
		light_time_d = light_time_q;
		light_d      = light_q;
		buzz_d       = buzz_q;
		fence_flag_d = fence_flag_q;
		fence_sil_d  = fence_sil_q;
		low_cnt_d    = low_cnt_q;
		link_flag_d  = link_flag_q;
		link_sil_d   = link_sil_q;
		silence_d    = silence_q;
		hold_d       = hold_q;
		settings_d   = settings_q;
		blink_d      = blink_q;
		released_d   = released_q;
		edit_thr_d   = edit_thr_q;
		thr_d        = thr_q;
		exit_d       = exit_q;
		charge_d     = charge_q;
		save_d       = 1'b0;

		if (item_s1.command == fmac_pkg::CMD_PACKET) begin
			// A packet refreshes the link and judges the fence reading.
			if (age_q > fmac_pkg::LINK_LOST_AGE) begin
				light_time_d = fmac_pkg::LIGHT_NORMAL;
			end
			age_d = 5'd0;

			if (low_read && !fence_sil_q) begin
				if (low_cnt_d != fmac_pkg::LOW_COUNT_MAX) begin
					low_cnt_d = low_cnt_d + 4'd1;
				end
				if (low_cnt_d > low_limit_q) begin
					fence_flag_d = 1'b1;
				end
			end
			if (!low_read) begin
				fence_sil_d = 1'b0;
				low_cnt_d   = 4'd0;
			end else if (fence_sil_q) begin
				light_time_d = fmac_pkg::LIGHT_NORMAL;
			end

			// Charging indicator rises quickly and decays slowly.
			if (item_s1.charge_state == fmac_pkg::CHARGE_ON &&
			    charge_q < fmac_pkg::CHARGE_CAP) begin
				charge_d = charge_q + fmac_pkg::CHARGE_STEP;
			end else if (item_s1.charge_state == fmac_pkg::CHARGE_OFF &&
			             charge_q != 6'd0) begin
				charge_d = charge_q - 6'd1;
			end

			silence_d   = 8'd0;
			link_flag_d = 1'b0;
			link_sil_d  = 1'b0;
		end else begin
			// Backlight and link age.
			if (btn) begin
				light_d      = 1'b1;
				light_time_d = fmac_pkg::LIGHT_PRESS;
			end
			if (age_d < fmac_pkg::LINK_AGE_CAP) begin
				age_d = age_d + 5'd1;
				if (age_d == fmac_pkg::LINK_LOST_AGE) begin
					light_time_d = fmac_pkg::LIGHT_NORMAL;
				end
			end
			if (light_time_d != 5'd0) begin
				light_time_d = light_time_d - 5'd1;
				if (light_time_d > 5'd1) begin
					light_d = 1'b1;
				end
				if (light_time_d == 5'd1) begin
					light_d = 1'b0;
				end
			end

			// Buzzer toggles while any alarm is up.
			if (fence_flag_d || link_flag_d) begin
				buzz_d       = ~buzz_d;
				light_time_d = fmac_pkg::LIGHT_ALARM;
			end else begin
				buzz_d = 1'b0;
			end
			if (fence_flag_d && btn) begin
				fence_flag_d = 1'b0;
				fence_sil_d  = 1'b1;
			end

			// Link silence counting.
			if (!link_sil_d) begin
				if (silence_d != fmac_pkg::SILENCE_MAX) begin
					silence_d = silence_d + 8'd1;
				end
				if (silence_d > link_ticks_q) begin
					link_flag_d = 1'b1;
				end
			end
			if (link_flag_d && btn) begin
				link_flag_d = 1'b0;
				link_sil_d  = 1'b1;
			end

			// Long press detection.
			if (!fence_flag_d && !link_flag_d && !settings_d && btn) begin
				if (hold_d != fmac_pkg::HOLD_MAX) begin
					hold_d = hold_d + 5'd1;
				end
				if (hold_d > long_press_q) begin
					settings_d = 1'b1;
					exit_d     = fmac_pkg::EXIT_TICKS;
				end
			end else begin
				hold_d = 5'd0;
			end

			// Settings mode: each new press steps the threshold; inactivity exits.
			if (settings_d) begin
				blink_d = blink_d + 2'd1;
				if (btn) begin
					if (released_d) begin
						released_d = 1'b0;
						edit_thr_d = (edit_thr_d >= fmac_pkg::THR_MAX) ?
						             3'd0 : edit_thr_d + 3'd1;
						exit_d     = fmac_pkg::EXIT_TICKS;
					end
				end else begin
					released_d = 1'b1;
				end
				if (exit_d != 5'd0) begin
					exit_d = exit_d - 5'd1;
				end
				if (exit_d == 5'd0) begin
					settings_d = 1'b0;
					blink_d    = 2'd0;
					thr_d      = edit_thr_d;
					save_d     = 1'b1;
				end
			end
		end
	end

	// Result fields are read off the updated state.
	always_comb begin
		result_s1.buzzer_on         = buzz_d;
		result_s1.backlight_on      = light_d;
		result_s1.fence_alarm       = fence_flag_d;
		result_s1.link_alarm        = link_flag_d;
		result_s1.link_lost         = age_d >= fmac_pkg::LINK_LOST_AGE;
		result_s1.in_settings       = settings_d;
		result_s1.marker_visible    = blink_d < 2'd2;
		result_s1.active_threshold  = thr_d;
		result_s1.pending_threshold = edit_thr_d;
		result_s1.charging_shown    = charge_d != 6'd0;
		result_s1.save_request      = save_d;
	end

	// Configuration and state registers; a threshold write also reloads both thresholds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_ticks_q <= fmac_pkg::LINK_TICKS_RST;
			low_limit_q  <= fmac_pkg::LOW_LIMIT_RST;
			long_press_q <= fmac_pkg::LONG_PRESS_RST;
			age_q        <= fmac_pkg::LINK_AGE_RST;
			light_time_q <= fmac_pkg::LIGHT_NORMAL;
			light_q      <= 1'b0;
			buzz_q       <= 1'b0;
			fence_flag_q <= 1'b0;
			fence_sil_q  <= 1'b0;
			low_cnt_q    <= 4'd0;
			link_flag_q  <= 1'b0;
			link_sil_q   <= 1'b0;
			silence_q    <= 8'd0;
			hold_q       <= 5'd0;
			settings_q   <= 1'b0;
			blink_q      <= 2'd0;
			released_q   <= 1'b0;
			edit_thr_q   <= fmac_pkg::clamp_thr(fmac_pkg::SAVED_THR_RST);
			thr_q        <= fmac_pkg::clamp_thr(fmac_pkg::SAVED_THR_RST);
			exit_q       <= 5'd0;
			charge_q     <= 6'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fmac_pkg::REG_SAVED_THRESHOLD: begin
					thr_q      <= fmac_pkg::clamp_thr(cfg_data[2:0]);
					edit_thr_q <= fmac_pkg::clamp_thr(cfg_data[2:0]);
				end
				fmac_pkg::REG_LINK_ALARM_TICKS:  link_ticks_q <= cfg_data[7:0];
				fmac_pkg::REG_LOW_READING_LIMIT: low_limit_q  <= cfg_data[3:0];
				fmac_pkg::REG_LONG_PRESS_TICKS:  long_press_q <= cfg_data[4:0];
				default: ;
			endcase
		end else if (valid_s1) begin
			age_q        <= age_d;
			light_time_q <= light_time_d;
			light_q      <= light_d;
			buzz_q       <= buzz_d;
			fence_flag_q <= fence_flag_d;
			fence_sil_q  <= fence_sil_d;
			low_cnt_q    <= low_cnt_d;
			link_flag_q  <= link_flag_d;
			link_sil_q   <= link_sil_d;
			silence_q    <= silence_d;
			hold_q       <= hold_d;
			settings_q   <= settings_d;
			blink_q      <= blink_d;
			released_q   <= released_d;
			edit_thr_q   <= edit_thr_d;
			thr_q        <= thr_d;
			exit_q       <= exit_d;
			charge_q     <= charge_d;
		end
	end

endmodule

// ----- hw/rtl/fmac_outq.sv -----
// Two-entry result queue that lets the input side keep moving while a result waits.
module fmac_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fmac_pkg::out_item_t push_data,
	input  logic                pop,
	output logic                result_valid,
	output fmac_pkg::out_item_t result,
	output logic [1:0]          count
);

	fmac_pkg::out_item_t mem_q [2];
	logic [1:0]          count_q;
	logic                head_q;
	logic                tail_q;

	assign result_valid = count_q != 2'd0;
	assign result       = mem_q[head_q];
	assign count        = count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			head_q  <= 1'b0;
			tail_q  <= 1'b0;
		end else begin
			if (push) begin
				tail_q <= ~tail_q;
			end
			if (pop) begin
				head_q <= ~head_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/fence_monitor_alarm_controller.sv -----
// Path: an accepted beat is held in the input register, then its result is pushed into the
// result queue, and result_valid rises once the queue holds it.
// Throughput: one beat per cycle while item_stall is low; the input register and a two-entry
// result queue keep the input side taking beats while a result waits, until two beats are held.
// Reset (arst_n low, asynchronous): all counters and flags clear, link age starts at 10,
// backlight timer at 20, registers take their defaults and both thresholds load from
// the saved threshold. No beat is held across reset.
module fence_monitor_alarm_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  fmac_pkg::in_item_t              item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output fmac_pkg::out_item_t             result,
	input  logic                            cfg_wr_en,
	input  fmac_pkg::cfg_index_t            cfg_index,
	input  logic [fmac_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                valid_s1;
	fmac_pkg::in_item_t  item_s1;
	fmac_pkg::out_item_t result_s1;
	logic [1:0]          q_count;
	logic [1:0]          occupancy;
	logic                pop;
	logic                accept;

	// Credit check: the input register plus the queue never hold more than two beats.
	assign pop        = result_valid && !result_stall;
	assign occupancy  = q_count + {1'b0, valid_s1};
	assign item_stall = (occupancy == 2'd2) && !pop;
	assign accept     = item_valid && !item_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	fmac_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.result_s1 (result_s1)
	);

	fmac_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (valid_s1),
		.push_data    (result_s1),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result),
		.count        (q_count)
	);

endmodule

// ----- hw/rtl/fmac_checker.sv -----
// Port-level checks for the fence monitor alarm controller, bound to the top level.
module fmac_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_stall,
	input logic                result_valid,
	input logic                result_stall,
	input fmac_pkg::out_item_t result
);

	// A stalled result beat stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// With nothing waiting at the output there is always room for a new beat.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled while the output is empty");

	// Outside settings mode the marker is never in its dark phase.
	a_marker_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.in_settings |-> result.marker_visible)
		else $error("marker dark outside settings mode");

	// A save pulse comes only on leaving settings, with the edited threshold adopted.
	a_save_exit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.save_request |->
		!result.in_settings && result.active_threshold == result.pending_threshold)
		else $error("save pulse without settings exit");

	// Both thresholds stay in their legal range.
	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.active_threshold <= fmac_pkg::THR_MAX &&
		result.pending_threshold <= fmac_pkg::THR_MAX)
		else $error("threshold out of range");

endmodule

bind fence_monitor_alarm_controller fmac_checker u_fmac_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the fence monitor alarm controller.
module testbench;

	// Clock, reset and block ports; every input starts at a known value.
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	fmac_pkg::in_item_t   item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	fmac_pkg::out_item_t  result;
	logic                 cfg_wr_en = 1'b0;
	fmac_pkg::cfg_index_t cfg_index = fmac_pkg::REG_SAVED_THRESHOLD;
	logic [7:0]           cfg_data = '0;

	// Stimulus waiting for the driver and panel states waiting for the block.
	fmac_pkg::in_item_t  pending_items[$];
	fmac_pkg::out_item_t panel_expected[$];

	// Bookkeeping for the checks and the closing summary.
	int queued_total = 0;
	int sent_count = 0;
	int checked_count = 0;
	int mismatch_count = 0;
	int settings_count = 0;
	int save_pulses = 0;
	int fence_alarm_beats = 0;
	int link_alarm_beats = 0;

	// Register copies kept by the predictor.
	logic [2:0] cfg_saved;
	logic [7:0] cfg_link_ticks;
	logic [3:0] cfg_low_limit;
	logic [4:0] cfg_long_press;

	// Controller state kept by the predictor.
	logic [4:0] age_ticks;
	logic [4:0] light_timer;
	logic       light_q;
	logic       buzz_q;
	logic       fence_alarm_q;
	logic       fence_muted;
	logic [3:0] low_run;
	logic       link_alarm_q;
	logic       link_muted;
	logic [7:0] quiet_ticks;
	logic [4:0] press_run;
	logic       setup_mode;
	logic [1:0] blink_phase;
	logic       released_q;
	logic [2:0] edit_thr;
	logic [2:0] use_thr;
	logic [4:0] exit_timer;
	logic [5:0] charge_level;

	fence_monitor_alarm_controller DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Free-running clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bring the predictor to the state the block takes at reset.
	task automatic reset_panel_model();
		cfg_saved      = fmac_pkg::SAVED_THR_RST;
		cfg_link_ticks = fmac_pkg::LINK_TICKS_RST;
		cfg_low_limit  = fmac_pkg::LOW_LIMIT_RST;
		cfg_long_press = fmac_pkg::LONG_PRESS_RST;
		age_ticks      = fmac_pkg::LINK_AGE_RST;
		light_timer    = fmac_pkg::LIGHT_NORMAL;
		light_q        = 1'b0;
		buzz_q         = 1'b0;
		fence_alarm_q  = 1'b0;
		fence_muted    = 1'b0;
		low_run        = '0;
		link_alarm_q   = 1'b0;
		link_muted     = 1'b0;
		quiet_ticks    = '0;
		press_run      = '0;
		setup_mode     = 1'b0;
		blink_phase    = '0;
		released_q     = 1'b0;
		exit_timer     = '0;
		charge_level   = '0;
		use_thr        = (cfg_saved > fmac_pkg::THR_MAX) ? 3'd0 : cfg_saved;
		edit_thr       = use_thr;
	endtask

	// Work out the panel state that one beat leaves behind.
	task automatic predict_panel(input fmac_pkg::in_item_t it,
			output fmac_pkg::out_item_t panel);
		logic save;
		logic btn;
		save = 1'b0;
		btn  = it.button_pressed;
		if (it.command == fmac_pkg::CMD_PACKET) begin
			// A packet restarts the link timers and feeds the fence and charge logic.
			if (age_ticks > fmac_pkg::LINK_LOST_AGE) begin
				light_timer = fmac_pkg::LIGHT_NORMAL;
			end
			age_ticks = '0;
			if (it.fence_level <= {5'd0, use_thr} && !fence_muted) begin
				if (low_run < fmac_pkg::LOW_COUNT_MAX) begin
					low_run = low_run + 4'd1;
				end
				if (low_run > cfg_low_limit) begin
					fence_alarm_q = 1'b1;
				end
			end
			if (it.fence_level > {5'd0, use_thr}) begin
				fence_muted = 1'b0;
				low_run     = '0;
			end else if (fence_muted) begin
				light_timer = fmac_pkg::LIGHT_NORMAL;
			end
			if (it.charge_state == fmac_pkg::CHARGE_ON &&
			    charge_level < fmac_pkg::CHARGE_CAP) begin
				charge_level = charge_level + fmac_pkg::CHARGE_STEP;
			end else if (it.charge_state == fmac_pkg::CHARGE_OFF && charge_level != 0) begin
				charge_level = charge_level - 6'd1;
			end
			quiet_ticks  = '0;
			link_alarm_q = 1'b0;
			link_muted   = 1'b0;
		end else begin
			// Backlight timer and link age advance on a tick, the link age only up to its cap.
			if (btn) begin
				light_q     = 1'b1;
				light_timer = fmac_pkg::LIGHT_PRESS;
			end
			if (age_ticks < fmac_pkg::LINK_AGE_CAP) begin
				age_ticks = age_ticks + 5'd1;
				if (age_ticks == fmac_pkg::LINK_LOST_AGE) begin
					light_timer = fmac_pkg::LIGHT_NORMAL;
				end
			end
			if (light_timer != 0) begin
				light_timer = light_timer - 5'd1;
				if (light_timer > 1) begin
					light_q = 1'b1;
				end
				if (light_timer == 1) begin
					light_q = 1'b0;
				end
			end
			// Buzzer toggles while any alarm stands; the button silences each alarm.
			if (fence_alarm_q || link_alarm_q) begin
				buzz_q      = ~buzz_q;
				light_timer = fmac_pkg::LIGHT_ALARM;
			end else begin
				buzz_q = 1'b0;
			end
			if (fence_alarm_q && btn) begin
				fence_alarm_q = 1'b0;
				fence_muted   = 1'b1;
			end
			if (!link_muted) begin
				if (quiet_ticks < fmac_pkg::SILENCE_MAX) begin
					quiet_ticks = quiet_ticks + 8'd1;
				end
				if (quiet_ticks > cfg_link_ticks) begin
					link_alarm_q = 1'b1;
				end
			end
			if (link_alarm_q && btn) begin
				link_alarm_q = 1'b0;
				link_muted   = 1'b1;
			end
			// A long hold with no alarm enters the threshold editor.
			if (!fence_alarm_q && !link_alarm_q && !setup_mode && btn) begin
				if (press_run < fmac_pkg::HOLD_MAX) begin
					press_run = press_run + 5'd1;
				end
				if (press_run > cfg_long_press) begin
					setup_mode = 1'b1;
					exit_timer = fmac_pkg::EXIT_TICKS;
				end
			end else begin
				press_run = '0;
			end
			// In the editor each fresh press steps the threshold; inactivity leaves it.
			if (setup_mode) begin
				blink_phase = blink_phase + 2'd1;
				if (btn) begin
					if (released_q) begin
						released_q = 1'b0;
						edit_thr   = (edit_thr >= fmac_pkg::THR_MAX) ? 3'd0 : edit_thr + 3'd1;
						exit_timer = fmac_pkg::EXIT_TICKS;
					end
				end else begin
					released_q = 1'b1;
				end
				if (exit_timer != 0) begin
					exit_timer = exit_timer - 5'd1;
				end
				if (exit_timer == 0) begin
					setup_mode  = 1'b0;
					blink_phase = '0;
					use_thr     = edit_thr;
					save        = 1'b1;
				end
			end
		end
		panel.buzzer_on         = buzz_q;
		panel.backlight_on      = light_q;
		panel.fence_alarm       = fence_alarm_q;
		panel.link_alarm        = link_alarm_q;
		panel.link_lost         = (age_ticks >= fmac_pkg::LINK_LOST_AGE);
		panel.in_settings       = setup_mode;
		panel.marker_visible    = (blink_phase < 2);
		panel.active_threshold  = use_thr;
		panel.pending_threshold = edit_thr;
		panel.charging_shown    = (charge_level != 0);
		panel.save_request      = save;
	endtask

	// Write one register while the block is idle and mirror it in the predictor.
	task automatic write_reg(input fmac_pkg::cfg_index_t idx, input logic [7:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			fmac_pkg::REG_SAVED_THRESHOLD: begin
				cfg_saved = value[2:0];
				use_thr   = (cfg_saved > fmac_pkg::THR_MAX) ? 3'd0 : cfg_saved;
				edit_thr  = use_thr;
			end
			fmac_pkg::REG_LINK_ALARM_TICKS:  cfg_link_ticks = value;
			fmac_pkg::REG_LOW_READING_LIMIT: cfg_low_limit  = value[3:0];
			fmac_pkg::REG_LONG_PRESS_TICKS:  cfg_long_press = value[4:0];
		endcase
	endtask

	// Program all four registers for a new setting.
	task automatic write_setting(input logic [7:0] saved, input logic [7:0] link_ticks,
			input logic [7:0] low_limit, input logic [7:0] long_press);
		write_reg(fmac_pkg::REG_SAVED_THRESHOLD, saved);
		write_reg(fmac_pkg::REG_LINK_ALARM_TICKS, link_ticks);
		write_reg(fmac_pkg::REG_LOW_READING_LIMIT, low_limit);
		write_reg(fmac_pkg::REG_LONG_PRESS_TICKS, long_press);
		settings_count++;
	endtask

	task automatic add_beat(input logic cmd, input logic btn, input logic [7:0] level,
			input logic [7:0] charge);
		fmac_pkg::in_item_t it;
		it.command        = cmd;
		it.button_pressed = btn;
		it.fence_level    = level;
		it.charge_state   = charge;
		pending_items.push_back(it);
		queued_total++;
	endtask

	// A tick carries random packet bytes, which the block ignores.
	task automatic add_tick(input logic btn);
		add_beat(fmac_pkg::CMD_TICK, btn, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] random_charge();
		case ($urandom_range(0, 3))
			0, 1: random_charge = fmac_pkg::CHARGE_ON;
			2: random_charge = fmac_pkg::CHARGE_OFF;
			default: random_charge = 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Random part: mostly complete scenarios with random content, some noise.
	task automatic queue_random_phase(input int target);
		int first;
		int n;
		int k;
		first = queued_total;
		while (queued_total - first < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// Long hold, a few edits, then inactivity until the editor closes.
					n = int'(cfg_long_press) + 1 + $urandom_range(0, 3);
					for (k = 0; k < n; k++) add_tick(1'b1);
					n = $urandom_range(2, 12);
					for (k = 0; k < n; k++) add_tick(1'($urandom_range(0, 1)));
					n = int'(fmac_pkg::EXIT_TICKS) + $urandom_range(0, 3);
					for (k = 0; k < n; k++) begin
						if ($urandom_range(0, 9) == 0) begin
							add_beat(fmac_pkg::CMD_PACKET, 1'($urandom_range(0, 1)),
								8'($urandom_range(0, 255)), random_charge());
						end
						add_tick(1'b0);
					end
				end
				3, 4: begin
					// Run of low readings, buzzer ticks, silencing, then recovery.
					n = int'(cfg_low_limit) + $urandom_range(1, 3);
					for (k = 0; k < n; k++) begin
						add_beat(fmac_pkg::CMD_PACKET, 1'($urandom_range(0, 1)),
							8'($urandom_range(0, use_thr)), random_charge());
						if ($urandom_range(0, 2) == 0) add_tick(1'b0);
					end
					n = $urandom_range(1, 6);
					for (k = 0; k < n; k++) add_tick(1'b0);
					add_tick(1'b1);
					add_beat(fmac_pkg::CMD_PACKET, 1'b0, 8'($urandom_range(0, use_thr)),
						random_charge());
					add_tick(1'($urandom_range(0, 1)));
					add_beat(fmac_pkg::CMD_PACKET, 1'b0,
						8'($urandom_range(int'(use_thr) + 1, 255)), random_charge());
				end
				5: begin
					// Silence on the link, which may run past the link alarm limit, then a press and a packet.
					n = int'(cfg_link_ticks) + $urandom_range(1, 4);
					if (n > 70 && $urandom_range(0, 3) != 0) n = $urandom_range(20, 70);
					for (k = 0; k < n; k++) add_tick(1'b0);
					n = $urandom_range(1, 5);
					for (k = 0; k < n; k++) add_tick(1'b0);
					add_tick(1'b1);
					n = $urandom_range(0, 4);
					for (k = 0; k < n; k++) add_tick(1'($urandom_range(0, 1)));
					add_beat(fmac_pkg::CMD_PACKET, 1'b0, 8'($urandom_range(6, 255)),
						random_charge());
				end
				6: begin
					// Charging then discharging packets.
					n = $urandom_range(3, 14);
					for (k = 0; k < n; k++) begin
						add_beat(fmac_pkg::CMD_PACKET, 1'($urandom_range(0, 1)),
							8'($urandom_range(6, 255)), fmac_pkg::CHARGE_ON);
					end
					n = $urandom_range(3, 20);
					for (k = 0; k < n; k++) begin
						add_beat(fmac_pkg::CMD_PACKET, 1'($urandom_range(0, 1)),
							8'($urandom_range(0, 255)),
							($urandom_range(0, 4) == 0) ? random_charge() :
							fmac_pkg::CHARGE_OFF);
					end
				end
				default: begin
					// Unstructured beats.
					n = $urandom_range(1, 8);
					for (k = 0; k < n; k++) begin
						add_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							8'($urandom_range(0, 255)), random_charge());
					end
				end
			endcase
		end
	endtask

	// Wait until every beat has gone in and every result has come back.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_items.size() != 0 || item_valid || panel_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Sender: takes beats from the pending queue in bursts with random gaps.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin : drive_beats
		fmac_pkg::out_item_t panel;
		logic                slot_free;
		if (item_valid && !item_stall) begin
			predict_panel(item, panel);
			panel_expected.push_back(panel);
			sent_count++;
		end
		slot_free = !item_valid || !item_stall;
		if (slot_free) begin
			if (gap_left != 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (arst_n && pending_items.size() != 0) begin
				item       <= pending_items.pop_front();
				item_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern changes every so often, with a few long hold-offs.
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	int next_hold_at = 150;

	always @(posedge clk) begin : pace_results
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (checked_count >= next_hold_at) begin
			next_hold_at = next_hold_at + 400;
			hold_left    = $urandom_range(60, 120);
			result_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode_left  = $urandom_range(10, 80);
				stall_mode = $urandom_range(0, 2);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				default: result_stall <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("beat %0d: %s expected %0d, got %0d", checked_count, name, want, got);
			end
		end
	endtask

	// Monitor: each accepted result is checked against the oldest prediction.
	always @(posedge clk) begin : check_results
		fmac_pkg::out_item_t want;
		if (result_valid && !result_stall) begin
			if (panel_expected.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("result beat with no beat outstanding: %h", result);
				end
			end else begin
				want = panel_expected.pop_front();
				check_field("buzzer_on", want.buzzer_on, result.buzzer_on);
				check_field("backlight_on", want.backlight_on, result.backlight_on);
				check_field("fence_alarm", want.fence_alarm, result.fence_alarm);
				check_field("link_alarm", want.link_alarm, result.link_alarm);
				check_field("link_lost", want.link_lost, result.link_lost);
				check_field("in_settings", want.in_settings, result.in_settings);
				check_field("marker_visible", want.marker_visible, result.marker_visible);
				check_field("active_threshold", want.active_threshold,
					result.active_threshold);
				check_field("pending_threshold", want.pending_threshold,
					result.pending_threshold);
				check_field("charging_shown", want.charging_shown, result.charging_shown);
				check_field("save_request", want.save_request, result.save_request);
				if (want.save_request) save_pulses++;
				if (want.fence_alarm) fence_alarm_beats++;
				if (want.link_alarm) link_alarm_beats++;
			end
			checked_count++;
		end
	end

	// Main sequence: reset, directed beats, then random phases under several settings.
	initial begin : run_phases
		int p;
		reset_panel_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats under the reset setting.
		add_tick(1'b0);
		add_tick(1'b1);
		add_beat(fmac_pkg::CMD_PACKET, 1'b1, 8'd255, fmac_pkg::CHARGE_ON);
		add_beat(fmac_pkg::CMD_PACKET, 1'b0, 8'd255, fmac_pkg::CHARGE_OFF);
		add_beat(fmac_pkg::CMD_PACKET, 1'b0, 8'd200, 8'd2);
		add_beat(fmac_pkg::CMD_PACKET, 1'b1, 8'd128, 8'd255);
		add_beat(fmac_pkg::CMD_PACKET, 1'b0, 8'd255, fmac_pkg::CHARGE_OFF);
		for (p = 0; p < 7; p++) add_beat(fmac_pkg::CMD_PACKET, 1'b0, 8'd0, fmac_pkg::CHARGE_ON);
		add_tick(1'b0);
		add_tick(1'b0);
		add_tick(1'b1);
		add_beat(fmac_pkg::CMD_PACKET, 1'b0, 8'd0, fmac_pkg::CHARGE_OFF);
		add_beat(fmac_pkg::CMD_PACKET, 1'b0, 8'd1, 8'd0);
		add_tick(1'b1);
		add_tick(1'b0);
		wait_drained();

		// Low extremes with an out-of-range saved threshold.
		write_setting(8'd6, 8'd1, 8'd1, 8'd1);
		queue_random_phase(200);
		wait_drained();

		// High extremes, where the saturating counters never raise their events.
		write_setting(8'd5, 8'd255, 8'd15, 8'd31);
		queue_random_phase(200);
		wait_drained();

		// Random settings, mostly with short link limits.
		for (p = 0; p < 3; p++) begin
			write_setting(8'($urandom_range(0, 7)), 8'($urandom_range(1, 40)),
				8'($urandom_range(1, 15)), 8'($urandom_range(1, 31)));
			queue_random_phase(200);
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (panel_expected.size() != 0) begin
			mismatch_count++;
			$display("%0d predicted results never arrived", panel_expected.size());
		end
		$display("Checked %0d results from %0d beats under %0d register settings.",
			checked_count, sent_count, settings_count + 1);
		$display("Saw %0d save pulses, %0d fence-alarm and %0d link-alarm results,",
			save_pulses, fence_alarm_beats, link_alarm_beats);
		$display("with %0d mismatches.", mismatch_count);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog for a block that stops answering.
	initial begin : watchdog
		#1000000;
		$display("Timed out with %0d results outstanding.", panel_expected.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
